// ===== rtl/hmf_pkg.sv =====
package hmf_pkg;

	localparam int COUNT_BITS_DEF = 32;

	localparam int KEY_LEN = 16;
	localparam logic [31:0] LENGTH_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] HEADER_END = 32'h0D0A_0D0A;

	localparam logic [0:0] CMD_BYTE = 1'b0;
	localparam logic [0:0] CMD_CLOSE = 1'b1;

	localparam logic [1:0] ST_CONT = 2'd0;
	localparam logic [1:0] ST_DONE_LEN = 2'd1;
	localparam logic [1:0] ST_DONE_CLOSE = 2'd2;
	localparam logic [1:0] ST_CLOSED_EMPTY = 2'd3;

	localparam logic [1:0] PH_SEARCH = 2'd0;
	localparam logic [1:0] PH_BLANKS = 2'd1;
	localparam logic [1:0] PH_DIGITS = 2'd2;
	localparam logic [1:0] PH_DONE = 2'd3;

	// element 0 is the first character of the key
	localparam logic [0:KEY_LEN-1][7:0] KEY_TEXT = {
		8'h43, 8'h6F, 8'h6E, 8'h74, 8'h65, 8'h6E, 8'h74, 8'h2D,
		8'h4C, 8'h65, 8'h6E, 8'h67, 8'h74, 8'h68, 8'h3A, 8'h20
	};

	typedef struct packed {
		logic [0:0] cmd;
		logic [7:0] data_byte;
	} rx_beat_t;

	typedef struct packed {
		logic [7:0]  byte_out;
		logic        byte_valid;
		logic        in_body;
		logic        last;
		logic [1:0]  status;
		logic [31:0] body_length;
	} msg_beat_t;

	// control from the framer to the length parser
	typedef struct packed {
		logic step;     // header byte to consume
		logic hdr_end;  // header ends on this byte
		logic clear;    // message finished
	} parse_ctl_t;

	typedef struct packed {
		logic [31:0] length;      // stored length
		logic [31:0] length_eff;  // length as taken at header end
	} parse_info_t;

endpackage

// ===== rtl/hmf_parser.sv =====
module hmf_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  hmf_pkg::parse_ctl_t ctl,
	input  logic [7:0]         c,
	output hmf_pkg::parse_info_t info
);

	logic [4:0]  match_q;
	logic [1:0]  phase_q;
	logic        neg_q;
	logic [31:0] length_q;

	logic [4:0]  match_d;
	logic [1:0]  phase_d;
	logic        neg_d;
	logic [31:0] length_d;
	logic [34:0] tenfold;
	logic [31:0] digit_sum;
	logic        is_digit;
	logic        is_blank;

	assign is_digit = (c >= 8'h30) && (c <= 8'h39);
	assign is_blank = c inside {8'h20, [8'h09:8'h0D]};

	// multiply by ten with shifts, saturate to the largest positive int
	always_comb begin
		tenfold = {length_q, 3'b000} + {2'b00, length_q, 1'b0} + {31'd0, c[3:0]};
		digit_sum = (tenfold > {3'b000, hmf_pkg::LENGTH_MAX}) ? hmf_pkg::LENGTH_MAX
			: tenfold[31:0];
	end

	assign info.length = length_q;
	assign info.length_eff = ((phase_q == hmf_pkg::PH_SEARCH) || neg_q) ? 32'd0 : length_q;

	always_comb begin
		match_d = match_q;
		phase_d = phase_q;
		neg_d = neg_q;
		length_d = length_q;
		case (phase_q)
			hmf_pkg::PH_SEARCH: begin
				if ((match_q < 5'(hmf_pkg::KEY_LEN)) && (c == hmf_pkg::KEY_TEXT[match_q[3:0]]))
					match_d = match_q + 5'd1;
				else
					match_d = (c == hmf_pkg::KEY_TEXT[0]) ? 5'd1 : 5'd0;
				if (match_d >= 5'(hmf_pkg::KEY_LEN))
					phase_d = hmf_pkg::PH_BLANKS;
			end
			hmf_pkg::PH_BLANKS: begin
				if (is_blank) begin
					phase_d = hmf_pkg::PH_BLANKS;
				end else if (c == 8'h2B) begin
					phase_d = hmf_pkg::PH_DIGITS;
				end else if (c == 8'h2D) begin
					neg_d = 1'b1;
					phase_d = hmf_pkg::PH_DIGITS;
				end else if (is_digit) begin
					length_d = digit_sum;
					phase_d = hmf_pkg::PH_DIGITS;
				end else begin
					phase_d = hmf_pkg::PH_DONE;
				end
			end
			hmf_pkg::PH_DIGITS: begin
				if (is_digit)
					length_d = digit_sum;
				else
					phase_d = hmf_pkg::PH_DONE;
			end
			default: begin
				phase_d = phase_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= '0;
			phase_q <= hmf_pkg::PH_SEARCH;
			neg_q <= 1'b0;
			length_q <= '0;
		end else if (ctl.clear) begin
			match_q <= '0;
			phase_q <= hmf_pkg::PH_SEARCH;
			neg_q <= 1'b0;
			length_q <= '0;
		end else if (ctl.hdr_end) begin
			// the terminating LF never moves the parser, so freeze the length here
			match_q <= match_d;
			phase_q <= hmf_pkg::PH_DONE;
			neg_q <= neg_q;
			length_q <= info.length_eff;
		end else if (ctl.step) begin
			match_q <= match_d;
			phase_q <= phase_d;
			neg_q <= neg_d;
			length_q <= length_d;
		end
	end

endmodule

// ===== rtl/http_message_framer.sv =====
// channel  | dir | handshake          | payload
// rx       | in  | rx_valid/rx_stall  | rx_data  (cmd, data_byte)
// msg      | out | msg_valid/msg_stall| msg_data (byte_out .. body_length)
//
// One beat in gives one beat out. A beat is taken every cycle unless the
// output stalls; it is held in the input register and is framed on its way
// into the result register. The framing step (count increment, end
// position add and compare) sets the cycle time.
// arst_n clears all control and per-message state. A stalled result holds
// in its register while one more beat waits in the input register.
module http_message_framer #(
	parameter int COUNT_BITS = hmf_pkg::COUNT_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rx_valid,
	output logic              rx_stall,
	input  hmf_pkg::rx_beat_t rx_data,
	output logic              msg_valid,
	input  logic              msg_stall,
	output hmf_pkg::msg_beat_t msg_data
);

	localparam int SUM_BITS = ((COUNT_BITS > 32) ? COUNT_BITS : 32) + 1;
	localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

	// input register
	logic              valid_s1;
	hmf_pkg::rx_beat_t data_s1;

	// result register
	logic               msg_valid_q;
	hmf_pkg::msg_beat_t msg_data_q;

	// per-message state
	logic [COUNT_BITS-1:0] count_q;
	logic [31:0]           tail_q;
	logic [COUNT_BITS-1:0] end_q;

	logic                  advance;
	logic                  is_close;
	logic                  was_body;
	logic [COUNT_BITS-1:0] count_d;
	logic [31:0]           tail_d;
	logic                  hdr_end;
	logic [SUM_BITS-1:0]   end_sum;
	logic [COUNT_BITS-1:0] end_hdr;
	logic [COUNT_BITS-1:0] end_d;
	logic                  done;
	logic                  clear;
	hmf_pkg::msg_beat_t    res;
	hmf_pkg::parse_ctl_t   pctl;
	hmf_pkg::parse_info_t  pinfo;

	// move a beat on when the result register is empty or being drained
	assign advance = valid_s1 && (!msg_valid_q || !msg_stall);
	assign rx_stall = valid_s1 && !advance;
	assign msg_valid = msg_valid_q;
	assign msg_data = msg_data_q;

	assign is_close = (data_s1.cmd == hmf_pkg::CMD_CLOSE);
	assign was_body = (end_q != '0);

	always_comb begin
		count_d = (count_q != CMAX) ? count_q + 1'b1 : count_q;
		tail_d = {tail_q[23:0], data_s1.data_byte};
		// more than four bytes seen once this one counts
		hdr_end = !was_body && (count_q >= COUNT_BITS'(4)) && (tail_d == hmf_pkg::HEADER_END);
		end_sum = SUM_BITS'(count_d) + SUM_BITS'(pinfo.length_eff);
		// saturate the end position at the counter limit
		end_hdr = (end_sum > SUM_BITS'(CMAX)) ? CMAX : end_sum[COUNT_BITS-1:0];
		end_d = hdr_end ? end_hdr : end_q;
		done = (was_body || hdr_end) && (count_d >= end_d);
	end

	assign clear = advance && (is_close || done);

	assign pctl.step = advance && !is_close && !was_body;
	assign pctl.hdr_end = advance && !is_close && hdr_end;
	assign pctl.clear = clear;

	hmf_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (pctl),
		.c      (data_s1.data_byte),
		.info   (pinfo)
	);

	always_comb begin
		if (is_close) begin
			res.byte_out = 8'd0;
			res.byte_valid = 1'b0;
			res.in_body = 1'b0;
			res.last = 1'b1;
			res.status = (count_q == '0) ? hmf_pkg::ST_CLOSED_EMPTY : hmf_pkg::ST_DONE_CLOSE;
			res.body_length = was_body ? pinfo.length : 32'd0;
		end else begin
			res.byte_out = data_s1.data_byte;
			res.byte_valid = 1'b1;
			res.in_body = was_body;
			res.last = done;
			res.status = done ? hmf_pkg::ST_DONE_LEN : hmf_pkg::ST_CONT;
			// at header end the parser has not stored the final length yet
			res.body_length = hdr_end ? pinfo.length_eff : (was_body ? pinfo.length : 32'd0);
		end
	end

	// input register: load whenever nothing is held back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!rx_stall) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!rx_stall && rx_valid)
			data_s1 <= rx_data;
	end

	// result register: hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msg_valid_q <= 1'b0;
		end else if (advance) begin
			msg_valid_q <= 1'b1;
		end else if (!msg_stall) begin
			msg_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			msg_data_q <= res;
	end

	// count, tail and end position; drop them when the message finishes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			tail_q <= '0;
			end_q <= '0;
		end else if (clear) begin
			count_q <= '0;
			tail_q <= '0;
			end_q <= '0;
		end else if (advance) begin
			count_q <= count_d;
			tail_q <= tail_d;
			end_q <= end_d;
		end
	end

endmodule

// ===== bench/framing_checker.sv =====
module framing_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rx_valid,
	input  logic               rx_stall,
	input  hmf_pkg::rx_beat_t  rx_data,
	input  logic               msg_valid,
	input  logic               msg_stall,
	input  hmf_pkg::msg_beat_t msg_data,
	output int                 fail_count,
	output int                 open_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int COUNT_BITS = hmf_pkg::COUNT_BITS_DEF;
	localparam logic [63:0] COUNT_MAX = (64'd1 << COUNT_BITS) - 64'd1;

	// per-message framing state
	logic [63:0] seen_cnt;
	logic [31:0] last4;
	logic [63:0] end_at;
	int          key_pos;
	logic [1:0]  num_phase;
	logic        num_neg;
	logic [31:0] num_mag;

	hmf_pkg::msg_beat_t expected_msgs[$];
	hmf_pkg::msg_beat_t want;

	function void clear_msg();
		seen_cnt = '0;
		last4 = '0;
		end_at = '0;
		key_pos = 0;
		num_phase = hmf_pkg::PH_SEARCH;
		num_neg = 1'b0;
		num_mag = '0;
	endfunction

	function logic [31:0] push_digit(logic [31:0] mag, logic [7:0] c);
		logic [63:0] v;
		v = {32'd0, mag} * 64'd10 + {56'd0, c - 8'h30};
		return (v > {32'd0, hmf_pkg::LENGTH_MAX}) ? hmf_pkg::LENGTH_MAX : v[31:0];
	endfunction

	function void parse_header(logic [7:0] c);
		logic is_digit;
		is_digit = (c >= "0") && (c <= "9");
		case (num_phase)
			hmf_pkg::PH_SEARCH: begin
				if (key_pos < hmf_pkg::KEY_LEN && c == hmf_pkg::KEY_TEXT[key_pos])
					key_pos++;
				else
					key_pos = (c == hmf_pkg::KEY_TEXT[0]) ? 1 : 0;
				if (key_pos >= hmf_pkg::KEY_LEN)
					num_phase = hmf_pkg::PH_BLANKS;
			end
			hmf_pkg::PH_BLANKS: begin
				if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D)) begin
					// skip blanks before the sign
				end else if (c == "+") begin
					num_phase = hmf_pkg::PH_DIGITS;
				end else if (c == "-") begin
					num_neg = 1'b1;
					num_phase = hmf_pkg::PH_DIGITS;
				end else if (is_digit) begin
					num_mag = push_digit(num_mag, c);
					num_phase = hmf_pkg::PH_DIGITS;
				end else begin
					num_phase = hmf_pkg::PH_DONE;
				end
			end
			hmf_pkg::PH_DIGITS: begin
				if (is_digit)
					num_mag = push_digit(num_mag, c);
				else
					num_phase = hmf_pkg::PH_DONE;
			end
			default: ;
		endcase
	endfunction

	// work out the result beat for one input beat and advance the state
	function hmf_pkg::msg_beat_t frame_beat(hmf_pkg::rx_beat_t b);
		hmf_pkg::msg_beat_t r;
		logic was_body;
		logic done;
		logic [63:0] e;
		r = '0;
		if (b.cmd == hmf_pkg::CMD_CLOSE) begin
			r.last = 1'b1;
			r.status = (seen_cnt == 0) ? hmf_pkg::ST_CLOSED_EMPTY : hmf_pkg::ST_DONE_CLOSE;
			r.body_length = (end_at != 0) ? num_mag : 32'd0;
			clear_msg();
			return r;
		end
		was_body = (end_at != 0);
		if (seen_cnt < COUNT_MAX)
			seen_cnt++;
		last4 = {last4[23:0], b.data_byte};
		if (!was_body) begin
			parse_header(b.data_byte);
			if (seen_cnt > 4 && last4 == hmf_pkg::HEADER_END) begin
				if (num_phase == hmf_pkg::PH_SEARCH || num_neg)
					num_mag = '0;
				num_phase = hmf_pkg::PH_DONE;
				e = seen_cnt + {32'd0, num_mag};
				if (e < seen_cnt || e > COUNT_MAX)
					e = COUNT_MAX;
				end_at = e;
			end
		end
		done = (end_at != 0) && (seen_cnt >= end_at);
		r.byte_out = b.data_byte;
		r.byte_valid = 1'b1;
		r.in_body = was_body;
		r.last = done;
		r.status = done ? hmf_pkg::ST_DONE_LEN : hmf_pkg::ST_CONT;
		r.body_length = (end_at != 0) ? num_mag : 32'd0;
		if (done)
			clear_msg();
		return r;
	endfunction

	function void log_fail(string what);
		fail_count++;
		if (fail_count <= 10)
			$display("%0t ns: %s", $time, what);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_msg();
			expected_msgs.delete();
			fail_count = 0;
			open_count = 0;
		end else begin
			// compare the outgoing beat before queueing the incoming one
			if (msg_valid && !msg_stall) begin
				if (expected_msgs.size() == 0) begin
					log_fail($sformatf("unexpected beat: %p", msg_data));
				end else begin
					want = expected_msgs.pop_front();
					if (msg_data.byte_out !== want.byte_out ||
							msg_data.byte_valid !== want.byte_valid ||
							msg_data.in_body !== want.in_body ||
							msg_data.last !== want.last ||
							msg_data.status !== want.status ||
							msg_data.body_length !== want.body_length)
						log_fail($sformatf("mismatch: expected %p, got %p",
							want, msg_data));
				end
			end
			if (rx_valid && !rx_stall)
				expected_msgs.push_back(frame_beat(rx_data));
			open_count = expected_msgs.size();
		end
	end

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PHASE_BEATS = 410;   // random beats per phase
	localparam int QUIET_LIMIT = 2000;  // cycles with no beat moving
	localparam int HOLD_CYCLES = 300;   // long receiver hold-off
	localparam int TAIL_CYCLES = 10;    // settle time after the last result
	localparam logic [7:0] CR = 8'h0D;
	localparam logic [7:0] LF = 8'h0A;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               rx_valid = 1'b0;
	logic               rx_stall;
	hmf_pkg::rx_beat_t  rx_data = '0;
	logic               msg_valid;
	logic               msg_stall = 1'b0;
	hmf_pkg::msg_beat_t msg_data;
	int                 fail_count;
	int                 open_count;

	// idle chances in percent, and which phase the run is in
	int send_idle = 7;
	int recv_idle = 47;
	int stim_phase = 0;
	int beats_sent = 0;

	// beats planned for the next message, sent in order
	hmf_pkg::rx_beat_t tx_plan[$];

	always #10 clk = ~clk;

	http_message_framer uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx_valid  (rx_valid),
		.rx_stall  (rx_stall),
		.rx_data   (rx_data),
		.msg_valid (msg_valid),
		.msg_stall (msg_stall),
		.msg_data  (msg_data)
	);

	framing_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx_valid   (rx_valid),
		.rx_stall   (rx_stall),
		.rx_data    (rx_data),
		.msg_valid  (msg_valid),
		.msg_stall  (msg_stall),
		.msg_data   (msg_data),
		.fail_count (fail_count),
		.open_count (open_count)
	);

	function automatic void add_beat(logic [0:0] c, logic [7:0] d);
		hmf_pkg::rx_beat_t x;
		x.cmd = c;
		x.data_byte = d;
		tx_plan.push_back(x);
	endfunction

	function automatic void add_text(string s);
		for (int i = 0; i < s.len(); i++)
			add_beat(hmf_pkg::CMD_BYTE, s[i]);
	endfunction

	function automatic void add_crlf();
		add_beat(hmf_pkg::CMD_BYTE, CR);
		add_beat(hmf_pkg::CMD_BYTE, LF);
	endfunction

	// space half of the time, otherwise one of TAB, LF, VT, FF, CR
	function automatic logic [7:0] pick_blank();
		if ($urandom_range(0, 1) == 0)
			return 8'h20;
		return 8'h09 + 8'($urandom_range(0, 4));
	endfunction

	// Plan one HTTP message: a start line, optional filler lines, an optional
	// length line in one of many shapes, the blank line and a body. Well-formed
	// lengths get exactly that many body bytes; the rest end by a close.
	function automatic void plan_message();
		int    key_form;
		int    val_form;
		int    body_n;
		int    v;
		int    cut;
		bit    by_len;
		bit    key_in_body;
		string key;
		string late_key;
		key = "Content-Length: ";
		late_key = "Content-Length: 7";
		by_len = 1'b0;
		body_n = $urandom_range(0, 4);
		add_text("M");
		add_crlf();
		repeat ($urandom_range(0, 2)) begin
			// filler line; random value may be a zero byte or any other
			add_text("X-");
			add_beat(hmf_pkg::CMD_BYTE, 8'($urandom_range(0, 255)));
			add_crlf();
		end
		key_form = $urandom_range(0, 15);
		if (key_form != 0) begin
			case (key_form)
				1: key[$urandom_range(0, 15)] = 8'h61 + 8'($urandom_range(0, 25));
				2: key = "content-length: ";
				3: key = {"C", key};
				4: key = "Content-Length:";
				default: ;
			endcase
			add_text(key);
			repeat ($urandom_range(0, 2))
				add_beat(hmf_pkg::CMD_BYTE, pick_blank());
			val_form = $urandom_range(0, 11);
			v = $urandom_range(0, 24);
			case (val_form)
				0: add_text("+");
				1: add_text("-");
				2: add_text($sformatf("-%0d", v + 1));
				3: add_text("99999999999");
				4: add_text("2147483647");
				5: add_text("4294967301");
				6: add_text("abc");
				7: begin
					add_text($sformatf("+%0d", v));
					by_len = 1'b1;
				end
				8: begin
					add_text($sformatf("00%0d", v));
					by_len = 1'b1;
				end
				default: begin
					add_text($sformatf("%0d", v));
					by_len = 1'b1;
				end
			endcase
			if (by_len && (key_form == 3 || key_form >= 5))
				body_n = v;
			else
				by_len = 1'b0;
			add_crlf();
			// a second length line is ignored once a first one has been recognized
			if ($urandom_range(0, 5) == 0) begin
				add_text("Content-Length: 3");
				add_crlf();
			end
		end
		add_crlf();
		// now and then carry a length line inside the body
		key_in_body = (body_n >= late_key.len()) && ($urandom_range(0, 2) == 0);
		for (int i = 0; i < body_n; i++) begin
			if (key_in_body && i < late_key.len())
				add_beat(hmf_pkg::CMD_BYTE, late_key[i]);
			else
				add_beat(hmf_pkg::CMD_BYTE, 8'($urandom_range(0, 255)));
		end
		if (!by_len || $urandom_range(0, 4) == 0)
			add_beat(hmf_pkg::CMD_CLOSE, 8'($urandom_range(0, 255)));
		// drop the connection somewhere in the middle
		if ($urandom_range(0, 9) == 0) begin
			cut = $urandom_range(1, tx_plan.size());
			while (tx_plan.size() > cut)
				void'(tx_plan.pop_back());
			add_beat(hmf_pkg::CMD_CLOSE, 8'($urandom_range(0, 255)));
		end
	endfunction

	// short burst of raw beats, closes included
	function automatic void plan_noise();
		repeat ($urandom_range(1, 4))
			add_beat(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
	endfunction

	// Offer one beat from a falling edge; hold it until accepted, then
	// return on the next falling edge with valid still high.
	task automatic send_beat(input hmf_pkg::rx_beat_t b);
		while ($urandom_range(0, 99) < send_idle) begin
			rx_valid <= 1'b0;
			@(negedge clk);
		end
		rx_valid <= 1'b1;
		rx_data <= b;
		@(posedge clk);
		while (rx_stall)
			@(posedge clk);
		beats_sent++;
		@(negedge clk);
	endtask

	task automatic send_plan();
		while (tx_plan.size() != 0)
			send_beat(tx_plan.pop_front());
	endtask

	// drop valid and wait until every expected result has come out
	task automatic wait_drained();
		rx_valid <= 1'b0;
		while (open_count != 0)
			@(negedge clk);
	endtask

	// stimulus and verdict
	initial begin
		bit paused;
		int start;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed beats: close on an empty connection, a header end that
		// needs a byte in front of it, extreme byte values, an empty-length
		// header followed by a byte and a close
		add_beat(hmf_pkg::CMD_CLOSE, 8'hFF);
		add_crlf();
		add_crlf();
		add_crlf();
		add_beat(hmf_pkg::CMD_BYTE, 8'h00);
		add_beat(hmf_pkg::CMD_BYTE, 8'hFF);
		add_beat(hmf_pkg::CMD_BYTE, 8'h80);
		add_beat(hmf_pkg::CMD_BYTE, 8'h7F);
		add_beat(hmf_pkg::CMD_CLOSE, 8'h00);
		add_text("A");
		add_crlf();
		add_crlf();
		add_text("Z");
		add_beat(hmf_pkg::CMD_CLOSE, 8'h55);
		send_plan();
		wait_drained();

		// random messages; idle receiver first, then idle sender, then none
		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					send_idle = 7;
					recv_idle = 47;
				end
				1: begin
					send_idle = 47;
					recv_idle = 7;
				end
				default: begin
					send_idle = 0;
					recv_idle = 0;
				end
			endcase
			stim_phase = ph;
			paused = 1'b0;
			start = beats_sent;
			while (beats_sent < start + PHASE_BEATS) begin
				if ($urandom_range(0, 19) == 0)
					plan_noise();
				else
					plan_message();
				send_plan();
				// pause once per phase until the block has emptied
				if (!paused && beats_sent > start + PHASE_BEATS / 2) begin
					wait_drained();
					paused = 1'b1;
				end
			end
			wait_drained();
		end

		repeat (TAIL_CYCLES) @(negedge clk);
		if (fail_count == 0)
			$display("PASS http_message_framer");
		else
			$display("FAIL http_message_framer");
		$finish;
	end

	// receiver: random stall, plus one long hold-off in the phase without
	// idling so that the block fills up and stalls its input
	initial begin : receiver
		int hold_left;
		bit held;
		hold_left = 0;
		held = 1'b0;
		forever begin
			@(negedge clk);
			if (!arst_n) begin
				msg_stall <= 1'b0;
			end else if (hold_left > 0) begin
				msg_stall <= 1'b1;
				hold_left--;
			end else if (stim_phase == 2 && !held) begin
				msg_stall <= 1'b1;
				hold_left = HOLD_CYCLES - 1;
				held = 1'b1;
			end else begin
				msg_stall <= ($urandom_range(0, 99) < recv_idle);
			end
		end
	end

	// end the run when no beat moves on either side for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (rx_valid && !rx_stall) || (msg_valid && !msg_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("FAIL http_message_framer");
		$finish;
	end

endmodule
